// ----- design/hid_key_report_diff_defines.svh -----
// ----------------------------------------------------------------------------
// hid_key_report_diff_defines.svh
// Assertion macros shared by the report diff block.
// ----------------------------------------------------------------------------
`ifndef HID_KEY_REPORT_DIFF_DEFINES_SVH
`define HID_KEY_REPORT_DIFF_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled during rst.
`define HKRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled during rst.
`define HKRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/hkrd_pkg.sv -----
// ----------------------------------------------------------------------------
// hkrd_pkg
// Types, key codes and event kinds of the keyboard report diff block.
// ----------------------------------------------------------------------------
package hkrd_pkg;

  localparam logic [7:0] KEY_CAPSLOCK = 8'h39;
  localparam logic [7:0] KEY_ROLLOVER = 8'h01;

  localparam logic [7:0] CTRL_MASK  = 8'h11;
  localparam logic [7:0] SHIFT_MASK = 8'h22;
  localparam logic [7:0] ALT_MASK   = 8'h44;
  localparam logic [7:0] GUI_MASK   = 8'h88;

  localparam int HOTKEY_COUNT = 14;
  localparam logic [7:0] HOTKEY_CODES [HOTKEY_COUNT] = '{
    8'h19, 8'h0E, 8'h17, 8'h0F, 8'h13, 8'h2E, 8'h2D,
    8'h57, 8'h56, 8'h2F, 8'h30, 8'h1A, 8'h16, 8'h15
  };

  typedef logic [1:0] event_kind_t;
  localparam event_kind_t EV_MODS = 2'd0;
  localparam event_kind_t EV_DOWN = 2'd1;
  localparam event_kind_t EV_UP   = 2'd2;
  localparam event_kind_t EV_HOT  = 2'd3;

  typedef struct packed {
    logic held;
    logic kept;
    logic hot;
    logic caps;
  } lane_flags_t;

  function automatic logic is_hotkey(input logic [7:0] code);
    logic hit;
    hit = 1'b0;
    for (int j = 0; j < HOTKEY_COUNT; j++) begin
      if (HOTKEY_CODES[j] == code) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ----- design/hid_key_report_diff.sv -----
// ----------------------------------------------------------------------------
// hid_key_report_diff
// Keyboard report diff: one report in, a burst of key and modifier events out.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_wen                cfg_wdata (swap Alt/GUI bits 2 and 3)
//   in       in         in_valid / in_stall    modifier_bits, key_slot0..5
//   out      out        out_valid / out_stall  event_kind .. last_event
//
// One event leaves per cycle while out_stall is low; a report holds in_stall
// until the last pick of its events, at most 2*KEY_SLOTS+1, which the event
// serializer issues with a single pick each. A report with no events does not
// load the serializer. The slot lanes compare in the cycle of acceptance, so
// the next report may enter in the cycle of the last pick.
// rst clears the stored report, the swap register and all valids.
// out_stall holds the output register and, through the serializer, the input.
// ----------------------------------------------------------------------------
`include "hid_key_report_diff_defines.svh"

module hid_key_report_diff #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            modifier_bits,
  input  logic [7:0]            key_slot0,
  input  logic [7:0]            key_slot1,
  input  logic [7:0]            key_slot2,
  input  logic [7:0]            key_slot3,
  input  logic [7:0]            key_slot4,
  input  logic [7:0]            key_slot5,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hkrd_pkg::event_kind_t event_kind,
  output logic [7:0]            current_modifiers,
  output logic [7:0]            previous_modifiers,
  output logic [7:0]            keycode,
  output logic                  last_event
);
  import hkrd_pkg::*;

  localparam int IN_SLOTS = 6;

  logic                        swap_alt_gui;
  logic [7:0]                  stored_mods;
  logic [KEY_SLOTS-1:0][7:0]   stored_keys;

  logic [IN_SLOTS-1:0][7:0]    in_slots;
  logic [KEY_SLOTS-1:0][7:0]   keys;
  logic [7:0]                  mods;
  lane_flags_t [KEY_SLOTS-1:0] flags;
  logic [2*KEY_SLOTS:0]        mask;
  logic                        hot;
  logic [7:0]                  hot_code;
  logic                        accept;
  logic                        load;
  logic                        accept_ok;
  logic                        busy;

  assign in_slots = {key_slot5, key_slot4, key_slot3, key_slot2, key_slot1, key_slot0};
  assign mods = swap_alt_gui ? {modifier_bits[7:4], modifier_bits[2], modifier_bits[3],
                                modifier_bits[1:0]}
                             : modifier_bits;

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
    if (i < IN_SLOTS) begin : g_real
      assign keys[i] = in_slots[i];
    end else begin : g_blank
      assign keys[i] = 8'h00;
    end
    hkrd_lane #(.SLOTS(KEY_SLOTS), .LANE(i)) u_lane (
      .keys   (keys),
      .stored (stored_keys),
      .flags  (flags[i])
    );
  end

  hkrd_merge #(.SLOTS(KEY_SLOTS)) u_merge (
    .flags       (flags),
    .keys        (keys),
    .mods        (mods),
    .stored_mods (stored_mods),
    .mask        (mask),
    .hot         (hot),
    .hot_code    (hot_code)
  );

  assign in_stall = !accept_ok;
  assign accept   = in_valid && accept_ok;
  assign load     = accept && (mask != '0);

  hkrd_serial #(.SLOTS(KEY_SLOTS)) u_serial (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .load_mask     (mask),
    .load_hot      (hot),
    .load_hot_code (hot_code),
    .load_cur      (mods),
    .load_prev     (stored_mods),
    .load_keys     (keys),
    .load_old      (stored_keys),
    .accept_ok     (accept_ok),
    .busy          (busy),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_kind      (event_kind),
    .out_cur       (current_modifiers),
    .out_prev      (previous_modifiers),
    .out_code      (keycode),
    .out_last      (last_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_alt_gui <= 1'b0;
      stored_mods  <= 8'h00;
      stored_keys  <= '0;
    end else begin
      if (cfg_wen) swap_alt_gui <= cfg_wdata;
      if (accept && !hot) begin
        stored_mods <= mods;
        stored_keys <= keys;
      end
    end
  end

  `HKRD_ASSERT_NOW(a_stall_needs_job, !busy, !in_stall, "input stalled with no pending events")
  `HKRD_ASSERT_NOW(a_hot_is_last, out_valid && (event_kind == EV_HOT), last_event,
                   "hotkey event not marked last")
  `HKRD_ASSERT_NOW(a_mods_change_differs, out_valid && (event_kind == EV_MODS),
                   current_modifiers != previous_modifiers, "modifier event without change")
  `HKRD_ASSERT_NEXT(a_hot_keeps_state, accept && hot, stored_mods == $past(stored_mods),
                    "hotkey report overwrote stored modifiers")

endmodule

// ----- design/hkrd_lane.sv -----
// ----------------------------------------------------------------------------
// hkrd_lane
// One slot: match new code against stored codes and stored code against new.
// ----------------------------------------------------------------------------
module hkrd_lane #(
  parameter int SLOTS = 6,
  parameter int LANE  = 0
) (
  input  logic [SLOTS-1:0][7:0] keys,
  input  logic [SLOTS-1:0][7:0] stored,
  output hkrd_pkg::lane_flags_t flags
);
  import hkrd_pkg::*;

  logic [7:0] key_new;
  logic [7:0] key_old;
  logic       held_any;
  logic       kept_any;

  assign key_new = keys[LANE];
  assign key_old = stored[LANE];

  always_comb begin
    held_any = 1'b0;
    kept_any = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (key_new == stored[j]) held_any = 1'b1;
      if (keys[j] == key_old) kept_any = 1'b1;
    end
  end

  assign flags.held = held_any && (key_new != KEY_ROLLOVER);
  assign flags.kept = kept_any && (key_old != KEY_ROLLOVER);
  assign flags.hot  = is_hotkey(key_new);
  assign flags.caps = (key_new == KEY_CAPSLOCK);

endmodule

// ----- design/hkrd_merge.sv -----
// ----------------------------------------------------------------------------
// hkrd_merge
// Combine lane flags into the hotkey decision and the pending event mask.
// ----------------------------------------------------------------------------
module hkrd_merge #(
  parameter int SLOTS = 6
) (
  input  hkrd_pkg::lane_flags_t [SLOTS-1:0] flags,
  input  logic [SLOTS-1:0][7:0]             keys,
  input  logic [7:0]                        mods,
  input  logic [7:0]                        stored_mods,
  output logic [2*SLOTS:0]                  mask,
  output logic                              hot,
  output logic [7:0]                        hot_code
);
  import hkrd_pkg::*;

  localparam int MW = 2 * SLOTS + 1;

  logic [SLOTS-1:0] hot_vec;
  logic             caps;
  logic             single;
  logic             ctrl, shift, alt, gui;

  always_comb begin
    caps     = 1'b0;
    hot_code = 8'h00;
    for (int i = 0; i < SLOTS; i++) begin
      hot_vec[i] = flags[i].hot;
      if (flags[i].caps) caps = 1'b1;
      if (flags[i].hot) hot_code = keys[i];
    end
  end

  assign single = (hot_vec != '0) && ((hot_vec & (hot_vec - SLOTS'(1))) == '0);
  assign ctrl   = |(mods & CTRL_MASK);
  assign shift  = |(mods & SHIFT_MASK);
  assign alt    = |(mods & ALT_MASK);
  assign gui    = |(mods & GUI_MASK);
  assign hot    = single && ((caps && ctrl && shift) || (ctrl && gui && alt));

  always_comb begin
    if (hot) begin
      mask = MW'(1);
    end else begin
      mask[0] = (mods != stored_mods);
      for (int i = 0; i < SLOTS; i++) begin
        mask[1 + 2 * i] = !flags[i].held;
        mask[2 + 2 * i] = !flags[i].kept;
      end
    end
  end

endmodule

// ----- design/hkrd_serial.sv -----
// ----------------------------------------------------------------------------
// hkrd_serial
// Hold one report's pending events and issue them in order, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module hkrd_serial #(
  parameter int SLOTS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [2*SLOTS:0]      load_mask,
  input  logic                  load_hot,
  input  logic [7:0]            load_hot_code,
  input  logic [7:0]            load_cur,
  input  logic [7:0]            load_prev,
  input  logic [SLOTS-1:0][7:0] load_keys,
  input  logic [SLOTS-1:0][7:0] load_old,
  output logic                  accept_ok,
  output logic                  busy,
  input  logic                  out_stall,
  output logic                  out_valid,
  output hkrd_pkg::event_kind_t out_kind,
  output logic [7:0]            out_cur,
  output logic [7:0]            out_prev,
  output logic [7:0]            out_code,
  output logic                  out_last
);
  import hkrd_pkg::*;

  localparam int MW = 2 * SLOTS + 1;
  localparam int EW = $clog2(MW);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [MW-1:0]          mask;
  logic                   hot;
  logic [7:0]             hot_code;
  logic [7:0]             cur;
  logic [7:0]             prev;
  logic [SLOTS-1:0][7:0]  keys;
  logic [SLOTS-1:0][7:0]  old;

  logic                   advance;
  logic                   take;
  logic [MW-1:0]          rest;
  logic                   final_event;
  logic [EW-1:0]          sel;
  logic [EW-1:0]          sel_m1;
  logic [EW-1:0]          slot_wide;
  logic [SW-1:0]          slot;
  event_kind_t            kind;
  logic [7:0]             code;

  assign advance     = !out_valid || !out_stall;
  assign take        = busy && advance;
  assign rest        = mask & (mask - MW'(1));
  assign final_event = (rest == '0);
  assign accept_ok   = !busy || (take && final_event);

  always_comb begin
    sel = '0;
    for (int e = MW - 1; e >= 0; e--) begin
      if (mask[e]) sel = EW'(e);
    end
  end

  assign sel_m1    = sel - EW'(1);
  assign slot_wide = sel_m1 >> 1;
  assign slot      = slot_wide[SW-1:0];

  always_comb begin
    if (sel == '0) begin
      kind = hot ? EV_HOT : EV_MODS;
      code = hot ? hot_code : 8'h00;
    end else if (sel[0]) begin
      kind = EV_DOWN;
      code = keys[slot];
    end else begin
      kind = EV_UP;
      code = old[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= take;
      if (load) begin
        busy <= 1'b1;
      end else if (take && final_event) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_kind <= kind;
      out_cur  <= cur;
      out_prev <= prev;
      out_code <= code;
      out_last <= final_event;
    end
    if (load) begin
      mask     <= load_mask;
      hot      <= load_hot;
      hot_code <= load_hot_code;
      cur      <= load_cur;
      prev     <= load_prev;
      keys     <= load_keys;
      old      <= load_old;
    end else if (take) begin
      mask     <= rest;
    end
  end

endmodule
